### rtl/core/quicksort_pivot_trace_core_assert.svh
// ----------------------------------------------------------------------------
// quicksort pivot trace assertion macros
// concurrent assertion helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef QUICKSORT_PIVOT_TRACE_CORE_ASSERT_SVH
`define QUICKSORT_PIVOT_TRACE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define QSPT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qspt assertion failed");

// next-cycle implication
`define QSPT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qspt assertion failed");

`else

`define QSPT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define QSPT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/qspt_pkg.sv
// ----------------------------------------------------------------------------
// qspt_pkg
// shared sizes and controller/datapath command and status types
// ----------------------------------------------------------------------------
package qspt_pkg;

   // store depth and derived widths
   localparam int MAX_N  = 32;
   localparam int ADDR_W = $clog2(MAX_N);
   localparam int CNT_W  = $clog2(MAX_N + 1);
   localparam int DATA_W = 32;

   // element store read source
   typedef enum logic [2:0] {
      RD_NONE,
      RD_LO,
      RD_I,
      RD_J,
      RD_K
   } rd_op_type;

   // element store write source
   typedef enum logic [2:0] {
      WR_NONE,
      WR_LOAD,
      WR_I_RD,
      WR_J_AI,
      WR_LO_RD,
      WR_J_PV
   } wr_op_type;

   // range stack push source
   typedef enum logic [1:0] {
      PUSH_NONE,
      PUSH_ROOT,
      PUSH_RIGHT,
      PUSH_LEFT
   } push_op_type;

   // result register load
   typedef enum logic [1:0] {
      OUT_NONE,
      OUT_PIVOT,
      OUT_VALUE
   } out_op_type;

   // one stacked subrange
   typedef struct packed {
      logic [CNT_W-1:0] len;
      logic [CNT_W-1:0] lo;
   } range_type;

   // controller to datapath
   typedef struct packed {
      rd_op_type   rd_op;
      wr_op_type   wr_op;
      push_op_type push_op;
      out_op_type  out_op;
      logic        pop;
      logic        set_range;
      logic        set_pv;
      logic        set_ai;
      logic        inc_i;
      logic        dec_j;
      logic        set_j_last;
      logic        set_p_j;
      logic        clr_p;
      logic        clr_k;
      logic        inc_k;
      logic        clr_run;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sp_zero;
      logic n_ge2;
      logic i_ge_n;
      logic rd_ge_pv;
      logic j_lt_i;
      logic j_gt_i;
      logic out_free;
      logic k_last;
   } status_type;

endpackage

### rtl/core/qspt_dpath.sv
// ----------------------------------------------------------------------------
// qspt_dpath
// element store, range stack, scan indexes and result register
// ----------------------------------------------------------------------------
module qspt_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  qspt_pkg::cmd_type                   cmd,
   output qspt_pkg::status_type                status,
   input  logic signed [qspt_pkg::DATA_W-1:0]  req_value_in,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic                                rsp_kind,
   output logic signed [qspt_pkg::DATA_W-1:0]  rsp_data_out,
   output logic                                rsp_end_of_run
);

   localparam int AW = qspt_pkg::ADDR_W;
   localparam int CW = qspt_pkg::CNT_W;
   localparam int DW = qspt_pkg::DATA_W;

   // memories
   logic [DW-1:0]             store_mem [qspt_pkg::MAX_N];
   qspt_pkg::range_type       stack_mem [qspt_pkg::MAX_N];

   // control registers
   logic [CW-1:0]             count_ff, count_in;
   logic [CW-1:0]             sp_ff, sp_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [CW-1:0]             lo_ff, n_ff, i_ff, j_ff, p_ff, k_ff;
   logic signed [DW-1:0]      pv_ff, ai_ff, rd_data_ff;
   qspt_pkg::range_type       stk_rd_ff;
   logic                      rsp_kind_ff;
   logic signed [DW-1:0]      rsp_data_ff;
   logic                      rsp_end_ff;

   // address and data selection
   logic [CW-1:0]             addr_lo_i, addr_lo_j, sp_dec;
   logic                      rd_en, wr_en, push_en;
   logic [AW-1:0]             rd_addr, wr_addr;
   logic [DW-1:0]             wr_data;
   qspt_pkg::range_type       push_entry;
   logic                      full, sp_full;

   assign addr_lo_i = lo_ff + i_ff;
   assign addr_lo_j = lo_ff + j_ff;
   assign sp_dec    = sp_ff - CW'(1);
   assign full      = (count_ff == CW'(qspt_pkg::MAX_N));
   assign sp_full   = (sp_ff == CW'(qspt_pkg::MAX_N));

   // read address
   always_comb begin
      rd_en   = 1'b1;
      rd_addr = '0;
      unique case (cmd.rd_op)
         qspt_pkg::RD_LO: rd_addr = lo_ff[AW-1:0];
         qspt_pkg::RD_I:  rd_addr = addr_lo_i[AW-1:0];
         qspt_pkg::RD_J:  rd_addr = addr_lo_j[AW-1:0];
         qspt_pkg::RD_K:  rd_addr = k_ff[AW-1:0];
         default:         rd_en   = 1'b0;
      endcase
   end

   // write address and data
   always_comb begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = '0;
      unique case (cmd.wr_op)
         qspt_pkg::WR_LOAD: begin
            wr_en   = !full;
            wr_addr = count_ff[AW-1:0];
            wr_data = req_value_in;
         end
         qspt_pkg::WR_I_RD: begin
            wr_addr = addr_lo_i[AW-1:0];
            wr_data = rd_data_ff;
         end
         qspt_pkg::WR_J_AI: begin
            wr_addr = addr_lo_j[AW-1:0];
            wr_data = ai_ff;
         end
         qspt_pkg::WR_LO_RD: begin
            wr_addr = lo_ff[AW-1:0];
            wr_data = rd_data_ff;
         end
         qspt_pkg::WR_J_PV: begin
            wr_addr = addr_lo_j[AW-1:0];
            wr_data = pv_ff;
         end
         default: wr_en = 1'b0;
      endcase
   end

   // push entry, empty ranges are skipped
   always_comb begin
      push_entry = '0;
      unique case (cmd.push_op)
         qspt_pkg::PUSH_ROOT: begin
            push_entry.lo  = '0;
            push_entry.len = count_ff;
         end
         qspt_pkg::PUSH_RIGHT: begin
            push_entry.lo  = lo_ff + p_ff + CW'(1);
            push_entry.len = n_ff - p_ff - CW'(1);
         end
         qspt_pkg::PUSH_LEFT: begin
            push_entry.lo  = lo_ff;
            push_entry.len = p_ff;
         end
         default: push_entry = '0;
      endcase
      push_en = (cmd.push_op != qspt_pkg::PUSH_NONE) && (push_entry.len != '0) && !sp_full;
   end

   // element store, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   // range stack, registered read on pop
   always_ff @(posedge clock) begin
      if (push_en) begin
         stack_mem[sp_ff[AW-1:0]] <= push_entry;
      end
      if (cmd.pop) begin
         stk_rd_ff <= stack_mem[sp_dec[AW-1:0]];
      end
   end

   // element count and stack pointer
   always_comb begin
      count_in = count_ff;
      if (cmd.clr_run) begin
         count_in = '0;
      end else if (cmd.wr_op == qspt_pkg::WR_LOAD && !full) begin
         count_in = count_ff + CW'(1);
      end
      priority if (cmd.clr_run) begin
         sp_in = '0;
      end else if (push_en) begin
         sp_in = sp_ff + CW'(1);
      end else if (cmd.pop) begin
         sp_in = sp_dec;
      end else begin
         sp_in = sp_ff;
      end
   end

   // result register handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_op != qspt_pkg::OUT_NONE) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // scan indexes and captured words
   always_ff @(posedge clock) begin
      if (cmd.set_range) begin
         lo_ff <= stk_rd_ff.lo;
         n_ff  <= stk_rd_ff.len;
         i_ff  <= CW'(1);
         j_ff  <= stk_rd_ff.len - CW'(1);
      end else begin
         if (cmd.inc_i) begin
            i_ff <= i_ff + CW'(1);
         end
         if (cmd.set_j_last) begin
            j_ff <= n_ff - CW'(1);
         end else if (cmd.dec_j) begin
            j_ff <= j_ff - CW'(1);
         end
      end
      if (cmd.set_pv) begin
         pv_ff <= rd_data_ff;
      end
      if (cmd.set_ai) begin
         ai_ff <= rd_data_ff;
      end
      if (cmd.clr_p) begin
         p_ff <= '0;
      end else if (cmd.set_p_j) begin
         p_ff <= j_ff;
      end
      if (cmd.clr_k) begin
         k_ff <= '0;
      end else if (cmd.inc_k) begin
         k_ff <= k_ff + CW'(1);
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      unique case (cmd.out_op)
         qspt_pkg::OUT_PIVOT: begin
            rsp_kind_ff <= 1'b0;
            rsp_data_ff <= {{(DW-CW){1'b0}}, p_ff};
            rsp_end_ff  <= 1'b0;
         end
         qspt_pkg::OUT_VALUE: begin
            rsp_kind_ff <= 1'b1;
            rsp_data_ff <= rd_data_ff;
            rsp_end_ff  <= status.k_last;
         end
         default: begin
         end
      endcase
   end

   // status to controller
   always_comb begin
      status.sp_zero  = (sp_ff == '0);
      status.n_ge2    = (n_ff >= CW'(2));
      status.i_ge_n   = (i_ff >= n_ff);
      status.rd_ge_pv = (rd_data_ff >= pv_ff);
      status.j_lt_i   = (j_ff < i_ff);
      status.j_gt_i   = (j_ff > i_ff);
      status.out_free = !rsp_valid_ff || !rsp_stall;
      status.k_last   = (k_ff == count_ff - CW'(1));
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_end_of_run = rsp_end_ff;

endmodule

### rtl/core/qspt_ctrl.sv
// ----------------------------------------------------------------------------
// qspt_ctrl
// sequencer for load, partition, range stack walk and sorted readout
// ----------------------------------------------------------------------------
module qspt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_is_last,
   output logic                 req_stall,
   input  qspt_pkg::status_type status,
   output qspt_pkg::cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ROOT,
      ST_POP,
      ST_RANGE,
      ST_CHECK,
      ST_PIVOT,
      ST_SCAN_I,
      ST_I_DATA,
      ST_SCAN_J,
      ST_J_DATA,
      ST_SWAP,
      ST_FIN_RD,
      ST_FIN_DATA,
      ST_FIN_WR,
      ST_EMIT,
      ST_PUSH_R,
      ST_PUSH_L,
      ST_OUT_RD,
      ST_OUT_DATA
   } state_type;

   state_type state_ff, state_in;

   // items are taken only between runs
   assign req_stall = (state_ff != ST_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rd_op      = qspt_pkg::RD_NONE;
      cmd.wr_op      = qspt_pkg::WR_NONE;
      cmd.push_op    = qspt_pkg::PUSH_NONE;
      cmd.out_op     = qspt_pkg::OUT_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.wr_op = qspt_pkg::WR_LOAD;
               if (req_is_last) begin
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            cmd.push_op = qspt_pkg::PUSH_ROOT;
            state_in    = ST_POP;
         end
         ST_POP: begin
            if (status.sp_zero) begin
               cmd.clr_k = 1'b1;
               state_in  = ST_OUT_RD;
            end else begin
               cmd.pop  = 1'b1;
               state_in = ST_RANGE;
            end
         end
         ST_RANGE: begin
            cmd.set_range = 1'b1;
            state_in      = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.n_ge2) begin
               cmd.rd_op = qspt_pkg::RD_LO;
               state_in  = ST_PIVOT;
            end else begin
               cmd.clr_p = 1'b1;
               state_in  = ST_EMIT;
            end
         end
         ST_PIVOT: begin
            cmd.set_pv = 1'b1;
            state_in   = ST_SCAN_I;
         end
         // left scan, runs off the end into the last slot
         ST_SCAN_I: begin
            if (status.i_ge_n) begin
               cmd.set_j_last = 1'b1;
               state_in       = ST_FIN_RD;
            end else begin
               cmd.rd_op = qspt_pkg::RD_I;
               state_in  = ST_I_DATA;
            end
         end
         ST_I_DATA: begin
            cmd.set_ai = 1'b1;
            if (status.rd_ge_pv) begin
               state_in = ST_SCAN_J;
            end else begin
               cmd.inc_i = 1'b1;
               state_in  = ST_SCAN_I;
            end
         end
         // right scan, crossing ends the partition
         ST_SCAN_J: begin
            if (status.j_lt_i) begin
               state_in = ST_FIN_RD;
            end else begin
               cmd.rd_op = qspt_pkg::RD_J;
               state_in  = ST_J_DATA;
            end
         end
         ST_J_DATA: begin
            if (status.j_gt_i && !status.rd_ge_pv) begin
               cmd.wr_op = qspt_pkg::WR_I_RD;
               state_in  = ST_SWAP;
            end else begin
               cmd.dec_j = 1'b1;
               state_in  = ST_SCAN_J;
            end
         end
         ST_SWAP: begin
            cmd.wr_op = qspt_pkg::WR_J_AI;
            cmd.inc_i = 1'b1;
            state_in  = ST_SCAN_I;
         end
         // pivot swap into its final slot
         ST_FIN_RD: begin
            cmd.rd_op = qspt_pkg::RD_J;
            state_in  = ST_FIN_DATA;
         end
         ST_FIN_DATA: begin
            cmd.wr_op = qspt_pkg::WR_LO_RD;
            state_in  = ST_FIN_WR;
         end
         ST_FIN_WR: begin
            cmd.wr_op   = qspt_pkg::WR_J_PV;
            cmd.set_p_j = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_op = qspt_pkg::OUT_PIVOT;
               state_in   = ST_PUSH_R;
            end
         end
         // right part first so the left part pops next
         ST_PUSH_R: begin
            cmd.push_op = qspt_pkg::PUSH_RIGHT;
            state_in    = ST_PUSH_L;
         end
         ST_PUSH_L: begin
            cmd.push_op = qspt_pkg::PUSH_LEFT;
            state_in    = ST_POP;
         end
         // sorted readout
         ST_OUT_RD: begin
            cmd.rd_op = qspt_pkg::RD_K;
            state_in  = ST_OUT_DATA;
         end
         ST_OUT_DATA: begin
            if (status.out_free) begin
               cmd.out_op = qspt_pkg::OUT_VALUE;
               if (status.k_last) begin
                  cmd.clr_run = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  cmd.inc_k = 1'b1;
                  state_in  = ST_OUT_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/quicksort_pivot_trace_core.sv
// ----------------------------------------------------------------------------
// quicksort_pivot_trace_core
// Loading: one cycle per transaction; the transaction marked last starts the sort.
// Sort: the root range is pushed, then ranges are popped until the stack is empty; a
// single word emits its pivot at once, a longer range is partitioned (one read port).
// Readout: sorted words are read out in order, held by result stalls, and the next run
// is taken the cycle after the last word enters the result register.
// Reset clears the sequencer, element count, stack pointer and result valid.
// ----------------------------------------------------------------------------
`include "quicksort_pivot_trace_core_assert.svh"

module quicksort_pivot_trace_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [qspt_pkg::DATA_W-1:0]  req_value_in,
   input  logic                                req_is_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_kind,
   output logic signed [qspt_pkg::DATA_W-1:0]  rsp_data_out,
   output logic                                rsp_end_of_run
);

   qspt_pkg::cmd_type    cmd;
   qspt_pkg::status_type status;

   // sequencer
   qspt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_is_last),
      .req_stall   (req_stall),
      .status      (status),
      .cmd         (cmd)
   );

   // storage and result register
   qspt_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_value_in   (req_value_in),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_kind       (rsp_kind),
      .rsp_data_out   (rsp_data_out),
      .rsp_end_of_run (rsp_end_of_run)
   );

   // a last transaction always starts a sort
   `QSPT_ASSERT_NEXT(a_last_starts_sort, clock, reset, req_valid && !req_stall && req_is_last, req_stall)

   // pivot records never close a run
   `QSPT_ASSERT_IMPL(a_pivot_not_end, clock, reset, rsp_valid && !rsp_kind, !rsp_end_of_run)

   // a pending pivot record means the sort is still running
   `QSPT_ASSERT_IMPL(a_pivot_in_sort, clock, reset, rsp_valid && !rsp_kind, req_stall)

endmodule

### test/quicksort_pivot_trace_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quicksort_pivot_trace_core_tb
// Loads runs of signed words into the sorter and checks every pivot and sorted
// value transaction against a behavioral quicksort kept in the bench. A short
// table covers extremes, duplicates and the run-off-the-end pivot; random runs
// of assorted lengths and orderings follow, some of them overfilling the store.
// ----------------------------------------------------------------------------
module quicksort_pivot_trace_core_tb;

   // how a table row is checked
   typedef enum logic {
      ROW_BY_MODEL,
      ROW_SINGLE
   } row_check_type;

   typedef struct packed {
      logic [qspt_pkg::DATA_W-1:0] value;
      logic                        last;
      row_check_type               check;
   } stim_row_type;

   // one result transaction
   typedef struct packed {
      logic                        kind;
      logic [qspt_pkg::DATA_W-1:0] data;
      logic                        eor;
   } trace_rec_type;

   localparam logic [qspt_pkg::DATA_W-1:0] MIN_WORD = 32'h8000_0000;
   localparam logic [qspt_pkg::DATA_W-1:0] MAX_WORD = 32'h7FFF_FFFF;
   localparam logic              KIND_PIVOT = 1'b0;
   localparam logic              KIND_VALUE = 1'b1;
   localparam int                N_DIRECTED = 24;
   localparam int                RANDOM_WORDS = 186;

   // directed runs: single words read straight off, the rest by the sort model
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{MAX_WORD,     1'b1, ROW_SINGLE},
      '{MIN_WORD,     1'b1, ROW_SINGLE},
      '{32'h0,        1'b1, ROW_SINGLE},
      '{32'hFFFF_FFFF, 1'b1, ROW_SINGLE},
      '{MIN_WORD,     1'b0, ROW_BY_MODEL},
      '{MAX_WORD,     1'b1, ROW_BY_MODEL},
      '{MAX_WORD,     1'b0, ROW_BY_MODEL},
      '{MIN_WORD,     1'b1, ROW_BY_MODEL},
      '{32'd5,        1'b0, ROW_BY_MODEL},
      '{32'd1,        1'b0, ROW_BY_MODEL},
      '{32'd3,        1'b0, ROW_BY_MODEL},
      '{32'd2,        1'b1, ROW_BY_MODEL},
      '{32'd7,        1'b0, ROW_BY_MODEL},
      '{32'd7,        1'b0, ROW_BY_MODEL},
      '{32'd7,        1'b0, ROW_BY_MODEL},
      '{32'd7,        1'b1, ROW_BY_MODEL},
      '{32'd3,        1'b0, ROW_BY_MODEL},
      '{32'd9,        1'b0, ROW_BY_MODEL},
      '{32'hFFFF_FFFC, 1'b0, ROW_BY_MODEL},
      '{32'd3,        1'b0, ROW_BY_MODEL},
      '{MIN_WORD,     1'b0, ROW_BY_MODEL},
      '{32'd8,        1'b1, ROW_BY_MODEL},
      '{32'h5555_5555, 1'b0, ROW_BY_MODEL},
      '{32'hAAAA_AAAA, 1'b1, ROW_BY_MODEL}
   };

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic signed [qspt_pkg::DATA_W-1:0] req_value_in = '0;
   logic                               req_is_last = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_kind;
   logic signed [qspt_pkg::DATA_W-1:0] rsp_data_out;
   logic                               rsp_end_of_run;

   // sort model state
   logic signed [qspt_pkg::DATA_W-1:0] sort_store [qspt_pkg::MAX_N];
   int                                 sort_count = 0;
   qspt_pkg::range_type                span_stack [qspt_pkg::MAX_N];
   int                                 span_sp = 0;
   trace_rec_type                      pending_trace [$];

   int fail_count = 0;
   bit in_calm = 1'b0;
   bit out_calm = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   quicksort_pivot_trace_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value_in   (req_value_in),
      .req_is_last    (req_is_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_data_out   (rsp_data_out),
      .rsp_end_of_run (rsp_end_of_run)
   );

   function void log_failure(string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%0t: %s", $time, msg);
      end
   endfunction

   function void swap_store(int a, int b);
      logic signed [qspt_pkg::DATA_W-1:0] t;
      t = sort_store[a];
      sort_store[a] = sort_store[b];
      sort_store[b] = t;
   endfunction

   // first-word pivot, scans from both ends; returns pivot index within span
   function int partition_span(int lo, int n);
      logic signed [qspt_pkg::DATA_W-1:0] pv;
      int  i;
      int  j;
      bit  done;
      bit  scanning;
      pv = sort_store[lo];
      i = 1;
      j = n - 1;
      done = 1'b0;
      while (!done) begin
         if (i >= n) begin
            // every word after the pivot is smaller: pivot goes last
            j = n - 1;
            done = 1'b1;
         end else begin
            if (sort_store[lo + i] >= pv) begin
               scanning = 1'b1;
               while (scanning) begin
                  if (j > i && sort_store[lo + j] < pv) begin
                     swap_store(lo + i, lo + j);
                     scanning = 1'b0;
                  end else if (j < i) begin
                     done = 1'b1;
                     scanning = 1'b0;
                  end else begin
                     j--;
                  end
               end
            end
            if (!done) begin
               i++;
            end
         end
      end
      swap_store(lo, lo + j);
      return j;
   endfunction

   function void push_span(int lo, int n);
      if (n > 0 && span_sp < qspt_pkg::MAX_N) begin
         span_stack[span_sp] = '{len: qspt_pkg::CNT_W'(n), lo: qspt_pkg::CNT_W'(lo)};
         span_sp++;
      end
   endfunction

   // store one word; a last word sorts the run and, if kept, queues its trace
   function void sort_word(logic [qspt_pkg::DATA_W-1:0] value, logic last, bit keep);
      qspt_pkg::range_type top;
      int        lo;
      int        n;
      int        p;
      if (sort_count < qspt_pkg::MAX_N) begin
         sort_store[sort_count] = value;
         sort_count++;
      end
      if (!last) begin
         return;
      end
      span_sp = 0;
      push_span(0, sort_count);
      while (span_sp > 0) begin
         span_sp--;
         top = span_stack[span_sp];
         lo = int'(top.lo);
         n = int'(top.len);
         if (lo + n <= sort_count) begin
            p = (n >= 2) ? partition_span(lo, n) : 0;
            if (keep) begin
               pending_trace.push_back('{KIND_PIVOT, qspt_pkg::DATA_W'(p), 1'b0});
            end
            if (n >= 2) begin
               push_span(lo + p + 1, n - p - 1);
               push_span(lo, p);
            end
         end
      end
      if (keep) begin
         for (int k = 0; k < sort_count; k++) begin
            pending_trace.push_back('{KIND_VALUE, sort_store[k], k == sort_count - 1});
         end
      end
      sort_count = 0;
      span_sp = 0;
   endfunction

   // drive one transaction, then update the model once it is taken
   task automatic send_word(input logic [qspt_pkg::DATA_W-1:0] value, input logic last,
                            input row_check_type check);
      int gap;
      if ($urandom_range(0, 15) == 0) begin
         in_calm = !in_calm;
      end
      gap = in_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value_in <= value;
      req_is_last <= last;
      do @(posedge clock); while (req_stall);
      if (check == ROW_SINGLE) begin
         pending_trace.push_back('{KIND_PIVOT, '0, 1'b0});
         pending_trace.push_back('{KIND_VALUE, value, 1'b1});
      end
      sort_word(value, last, check == ROW_BY_MODEL);
   endtask

   // result side back-pressure
   initial begin
      int hold;
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            out_calm = !out_calm;
         end
         hold = out_calm ? 0 : $urandom_range(0, 15);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && !rsp_stall));
      end
   end

   // compare each accepted result with the oldest expected one
   always @(posedge clock) begin
      trace_rec_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (pending_trace.size() == 0) begin
            log_failure($sformatf("unexpected rsp: kind %0d data %0d end %0d",
                                  rsp_kind, rsp_data_out, rsp_end_of_run));
         end else begin
            want = pending_trace.pop_front();
            if (want.kind !== rsp_kind || want.data !== rsp_data_out ||
                want.eor !== rsp_end_of_run) begin
               log_failure($sformatf(
                  "rsp differs: want kind %0d data %0d end %0d, got kind %0d data %0d end %0d",
                  want.kind, $signed(want.data), want.eor,
                  rsp_kind, rsp_data_out, rsp_end_of_run));
            end
         end
      end
   end

   // stimulus
   initial begin
      int run_q [$];
      int run_len;
      int run_no;
      int shape;
      int pick;
      int sent;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < N_DIRECTED; r++) begin
         send_word(directed_rows[r].value, directed_rows[r].last, directed_rows[r].check);
      end

      // random runs: first one overfills the store, second fills it exactly
      sent = 0;
      run_no = 0;
      while (sent < RANDOM_WORDS) begin
         if (run_no == 0) begin
            run_len = qspt_pkg::MAX_N + 2;
         end else if (run_no == 1) begin
            run_len = qspt_pkg::MAX_N;
         end else if ($urandom_range(0, 7) == 0) begin
            run_len = $urandom_range(9, qspt_pkg::MAX_N + 4);
         end else begin
            run_len = $urandom_range(1, 8);
         end
         run_q.delete();
         repeat (run_len) begin
            pick = $urandom_range(0, 9);
            if (pick < 5) begin
               run_q.push_back(int'($urandom));
            end else if (pick < 8) begin
               run_q.push_back(int'($urandom_range(0, 6)) - 3);
            end else if (pick == 8) begin
               run_q.push_back(int'(MIN_WORD));
            end else begin
               run_q.push_back(int'(MAX_WORD));
            end
         end
         // presorted runs push the pivot to the ends of each span
         shape = $urandom_range(0, 3);
         if (shape == 1) begin
            run_q.sort();
         end else if (shape == 2) begin
            run_q.rsort();
         end
         foreach (run_q[k]) begin
            send_word(run_q[k], k == run_q.size() - 1, ROW_BY_MODEL);
         end
         sent += run_len;
         run_no++;
      end
      req_valid <= 1'b0;

      // drain
      while (pending_trace.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (pending_trace.size() != 0) begin
         log_failure($sformatf("%0d results never arrived", pending_trace.size()));
      end
      if (fail_count == 0) begin
         $display("quicksort_pivot_trace_core: match");
      end else begin
         $display("quicksort_pivot_trace_core: mismatch");
      end
      $finish;
   end

   // watchdog
   initial begin
      #1_000_000;
      $display("quicksort_pivot_trace_core: mismatch");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/qspt_pkg.sv
rtl/core/qspt_dpath.sv
rtl/core/qspt_ctrl.sv
rtl/core/quicksort_pivot_trace_core.sv
test/quicksort_pivot_trace_core_tb.sv
